// ----- src/rwbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rwbb_pkg
// Widths, codes and types shared by the rolling Bollinger band block.
// ----------------------------------------------------------------------------
package rwbb_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int HEAD_W     = $clog2(WINDOW_MAX);
   localparam int PRICE_W    = 24;
   localparam int LEN_W      = 7;
   localparam int BW_W       = 12;
   localparam int SUM_W      = 30;
   localparam int SQ_W       = 54;
   localparam int PROD_W     = SQ_W + LEN_W;
   localparam int ROOT_W     = 31;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int FRAC_W     = 8;
   localparam int SCALE_W    = BW_W + ROOT_W;
   localparam int DIV_W      = SCALE_W - FRAC_W;
   localparam int BAND_W     = 28;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20);
   localparam logic [BW_W-1:0]  BW_RESET  = BW_W'(512);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW_LENGTH = 2'd0,
      REG_BAND_WIDTH    = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ACCUM,
      ST_PRODUCT,
      ST_DIFF,
      ST_ROOT,
      ST_SCALE,
      ST_DIV_MID,
      ST_DIV_OFF,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic ram_we;
      logic root_start;
      logic div_start;
      logic out_load;
   } seq_ctrl_type;

endpackage

// ----- src/rwbb_req_if.sv -----
// ----------------------------------------------------------------------------
// rwbb_req_if
// Input channel: one price item with its restart flag.
// ----------------------------------------------------------------------------
interface rwbb_req_if import rwbb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] price;
   logic               restart;

   modport source (output valid, price, restart, input ready);
   modport sink   (input valid, price, restart, output ready);
endinterface

// ----- src/rwbb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rwbb_rsp_if
// Result channel: the three bands and the window-full flag.
// ----------------------------------------------------------------------------
interface rwbb_rsp_if import rwbb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [PRICE_W-1:0]       middle_band;
   logic [BAND_W-1:0]        upper_band;
   logic signed [BAND_W-1:0] lower_band;
   logic                     window_full;

   modport source (output valid, middle_band, upper_band, lower_band, window_full,
                   input ready);
   modport sink   (input valid, middle_band, upper_band, lower_band, window_full,
                   output ready);
endinterface

// ----- src/rwbb_csr_if.sv -----
// ----------------------------------------------------------------------------
// rwbb_csr_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface rwbb_csr_if import rwbb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/rwbb_ring_ram.sv -----
// ----------------------------------------------------------------------------
// rwbb_ring_ram
// Price ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rwbb_ring_ram import rwbb_pkg::*; (
   input  logic               clock,
   input  logic               we,
   input  logic [HEAD_W-1:0]  waddr,
   input  logic [PRICE_W-1:0] wdata,
   input  logic [HEAD_W-1:0]  raddr,
   output logic [PRICE_W-1:0] rdata
);

   logic [PRICE_W-1:0] mem [WINDOW_MAX];
   logic [PRICE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/rwbb_isqrt.sv -----
// ----------------------------------------------------------------------------
// rwbb_isqrt
// Floor square root, one result bit per cycle (restoring digit recurrence).
// ----------------------------------------------------------------------------
module rwbb_isqrt import rwbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  cur;
   logic [REM_W-1:0]  trial;

   always_comb begin
      cur     = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         rad_in = rad_ff << 2;
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- src/rwbb_div.sv -----
// ----------------------------------------------------------------------------
// rwbb_div
// Unsigned divide by the window length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwbb_div import rwbb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [LEN_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int REM_W = LEN_W + 1;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] cur;

   always_comb begin
      // remainder stays below the divisor, so its top bit is free to shift
      cur     = {rem_ff[LEN_W-1:0], quo_ff[DIV_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         if (cur >= {1'b0, dsr_ff}) begin
            rem_in = cur - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = cur;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- src/rolling_window_bollinger_bands_top.sv -----
// Sequence: accept, fetch of the oldest entry, accumulate; once the window
// is full, then products, difference, square root and two divides (mean,
// then scaled root). One item at a time: the next item is taken once the
// result has moved to the output register, which may still be waiting on rsp.
// Reset: synchronous, active high; empties the window, loads the register
// defaults (length 20, band width 2.0). The ring itself is not cleared.
// ----------------------------------------------------------------------------
// rolling_window_bollinger_bands_top
// Rolling mean and population deviation bands over a ring of prices.
// ----------------------------------------------------------------------------
module rolling_window_bollinger_bands_top import rwbb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rwbb_req_if.sink  req,
   rwbb_rsp_if.source rsp,
   rwbb_csr_if.sink  csr
);

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BW_W-1:0]    bw_ff, bw_in;
   logic [HEAD_W-1:0]  head_ff, head_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [PRICE_W-1:0] price_ff;
   logic [PRICE_W-1:0] old_ff;
   logic [SQ_W-1:0]    old_sq_ff;
   logic [SQ_W-1:0]    new_sq_ff;
   logic               full_ff;
   logic [PROD_W-1:0]  a_ff;
   logic [PROD_W-1:0]  b_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [PRICE_W-1:0] mid_ff;
   logic [DIV_W-1:0]   off_ff;
   logic               out_valid_ff, out_valid_in;
   logic [PRICE_W-1:0] out_mid_ff;
   logic [BAND_W-1:0]  out_up_ff;
   logic [BAND_W-1:0]  out_lo_ff;
   logic               out_full_ff;

   seq_ctrl_type       ctrl;

   logic [LEN_W-1:0]   n;
   logic               csr_we;
   logic               len_write;
   logic [HEAD_W-1:0]  rd_addr;
   logic [PRICE_W-1:0] rd_data;
   logic               full_old;
   logic               full_new;
   logic [PROD_W-1:0]  diff;
   logic               root_done;
   logic [ROOT_W-1:0]  root;
   logic               div_done;
   logic [DIV_W-1:0]   quotient;
   logic [DIV_W-1:0]   div_dividend;

   // effective window length: zero acts as one, clamp to the ring size
   always_comb begin
      if (len_ff == '0) begin
         n = LEN_W'(1);
      end else if (int'(len_ff) > WINDOW_MAX) begin
         n = LEN_W'(WINDOW_MAX);
      end else begin
         n = len_ff;
      end
   end

   // ---------------------------------------------------------------
   // Register port: always ready; writes are expected only while no
   // item is in flight
   // ---------------------------------------------------------------
   assign csr.ready = 1'b1;
   assign csr_we    = csr.valid;
   assign len_write = csr_we && (csr.index == REG_WINDOW_LENGTH);

   always_comb begin
      len_in = len_ff;
      bw_in  = bw_ff;
      if (len_write) begin
         len_in = csr.data[LEN_W-1:0];
      end
      if (csr_we && (csr.index == REG_BAND_WIDTH)) begin
         bw_in = csr.data[BW_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    begin
            if (req.valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:   state_in = ST_ACCUM;
         ST_ACCUM:   state_in = full_new ? ST_PRODUCT : ST_DONE;
         ST_PRODUCT: state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_ROOT;
         ST_ROOT:    begin
            if (root_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:   state_in = ST_DIV_MID;
         ST_DIV_MID: begin
            if (div_done) begin
               state_in = ST_DIV_OFF;
            end
         end
         ST_DIV_OFF: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE:    begin
            if (ctrl.out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:    ctrl.accept     = req.valid;
         ST_ACCUM:   ctrl.ram_we     = 1'b1;
         ST_DIFF:    ctrl.root_start = 1'b1;
         ST_SCALE:   ctrl.div_start  = 1'b1;
         ST_DIV_MID: ctrl.div_start  = div_done;
         ST_DONE:    ctrl.out_load   = !out_valid_ff || rsp.ready;
         default:    ctrl = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Window state: ring pointer, fill count and running sums
   // ---------------------------------------------------------------
   // Oldest entry sits N places behind the head (after restart the count
   // is zero, so whatever is read is discarded).
   assign rd_addr  = (req.restart ? HEAD_W'(0) : head_ff) - n[HEAD_W-1:0];
   assign full_old = (count_ff >= n);
   assign full_new = (count_in >= n);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      if (len_write || (ctrl.accept && req.restart)) begin
         head_in  = '0;
         count_in = '0;
         sum_in   = '0;
         sq_in    = '0;
      end else if (ctrl.ram_we) begin
         head_in = head_ff + 1'b1;
         if (full_old) begin
            sum_in = sum_ff - SUM_W'(old_ff) + SUM_W'(price_ff);
            sq_in  = sq_ff - old_sq_ff + new_sq_ff;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(price_ff);
            sq_in    = sq_ff + new_sq_ff;
         end
      end
   end

   rwbb_ring_ram u_ring (
      .clock (clock),
      .we    (ctrl.ram_we),
      .waddr (head_ff),
      .wdata (price_ff),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   // ---------------------------------------------------------------
   // Deviation: N*sumsq - sum^2, then the root
   // ---------------------------------------------------------------
   assign diff = (a_ff > b_ff) ? (a_ff - b_ff) : '0;

   rwbb_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.root_start),
      .radicand (RAD_W'(diff)),
      .done     (root_done),
      .root     (root)
   );

   // shared divider: mean first, then the scaled root (k*root/256)/N
   assign div_dividend = (state_ff == ST_SCALE) ? DIV_W'(sum_ff)
                                                : scale_ff[SCALE_W-1:FRAC_W];

   rwbb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (div_dividend),
      .divisor  (n),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---------------------------------------------------------------
   // Result register: parts the sequencer from the rsp handshake
   // ---------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctrl.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         bw_ff        <= BW_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         bw_ff        <= bw_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         price_ff <= req.price;
      end
      if (state_ff == ST_FETCH) begin
         old_ff    <= rd_data;
         old_sq_ff <= SQ_W'(rd_data) * SQ_W'(rd_data);
         new_sq_ff <= SQ_W'(price_ff) * SQ_W'(price_ff);
      end
      if (ctrl.ram_we) begin
         full_ff <= full_new;
         // while filling, all bands are the price itself
         mid_ff  <= price_ff;
         off_ff  <= '0;
      end
      if (state_ff == ST_PRODUCT) begin
         a_ff <= PROD_W'(sq_ff) * PROD_W'(n);
         b_ff <= PROD_W'(sum_ff) * PROD_W'(sum_ff);
      end
      if (state_ff == ST_SCALE) begin
         scale_ff <= SCALE_W'(bw_ff) * SCALE_W'(root);
      end
      if ((state_ff == ST_DIV_MID) && div_done) begin
         mid_ff <= quotient[PRICE_W-1:0];
      end
      if ((state_ff == ST_DIV_OFF) && div_done) begin
         off_ff <= quotient;
      end
      if (ctrl.out_load) begin
         out_mid_ff  <= mid_ff;
         out_up_ff   <= BAND_W'(mid_ff) + off_ff[BAND_W-1:0];
         out_lo_ff   <= BAND_W'(mid_ff) - off_ff[BAND_W-1:0];
         out_full_ff <= full_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.middle_band = out_mid_ff;
   assign rsp.upper_band  = out_up_ff;
   assign rsp.lower_band  = $signed(out_lo_ff);
   assign rsp.window_full = out_full_ff;

endmodule

// ----- dv/tb_rwbb_if.sv -----
// ----------------------------------------------------------------------------
// tb_rwbb_if
// Testbench-side note: the block's own interfaces are reused as they stand.
// ----------------------------------------------------------------------------
// The channel interfaces (rwbb_req_if, rwbb_rsp_if, rwbb_csr_if) come with the
// RTL sources; this file only holds the expected band values and the input tick type.
package tb_rwbb_types_pkg;
   import rwbb_pkg::*;

   typedef struct packed {
      logic [PRICE_W-1:0]       middle_band;
      logic [BAND_W-1:0]        upper_band;
      logic signed [BAND_W-1:0] lower_band;
      logic                     window_full;
   } band_result_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic               restart;
   } tick_type;
endpackage

// ----- dv/tb_rolling_window_bollinger_bands_top.sv -----
// ----------------------------------------------------------------------------
// tb_rolling_window_bollinger_bands_top
// Checks the rolling Bollinger band block against an in-bench band predictor
// across several window lengths and band widths, with random sender bursts
// and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rolling_window_bollinger_bands_top;
   import rwbb_pkg::*;
   import tb_rwbb_types_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_WAIT  = 200;
   localparam int MAX_ITEMS   = 4096;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rwbb_req_if req ();
   rwbb_rsp_if rsp ();
   rwbb_csr_if csr ();

   rolling_window_bollinger_bands_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --- predictor state: own copy of the ring, sums and registers ---------
   logic [PRICE_W-1:0] hist_ring [WINDOW_MAX];
   int unsigned        hist_head;
   int unsigned        hist_count;
   logic [63:0]        sum_acc;
   logic [63:0]        sq_acc;
   logic [LEN_W-1:0]   len_reg;
   logic [BW_W-1:0]    bw_reg;

   // pending items and expected results, each with write and read counters
   band_result_type band_mem [MAX_ITEMS];
   tick_type        tick_mem [MAX_ITEMS];
   int              band_wr = 0;
   int              band_rd = 0;
   int              tick_wr = 0;
   int              tick_rd = 0;

   int mismatches = 0;
   int cycles     = 0;

   function automatic void clear_window();
      hist_head  = 0;
      hist_count = 0;
      sum_acc    = '0;
      sq_acc     = '0;
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      r = '0;
      for (int b = 39; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (128'(c) * 128'(c) <= v) r = c;
      end
      return r;
   endfunction

   // Works out the bands for one tick and advances the window.
   function automatic band_result_type predict_bands(tick_type t);
      band_result_type res;
      int unsigned  n;
      logic [63:0]  old;
      logic [127:0] spread;
      logic [127:0] a;
      logic [127:0] b;
      logic [63:0]  mid;
      logic [63:0]  off;
      n = (len_reg == 0) ? 1 : ((len_reg > WINDOW_MAX) ? WINDOW_MAX : len_reg);
      if (t.restart) clear_window();
      if (hist_count >= n) begin
         old = hist_ring[(hist_head + WINDOW_MAX - n) % WINDOW_MAX];
         sum_acc -= old;
         sq_acc  -= old * old;
      end else begin
         hist_count++;
      end
      hist_ring[hist_head] = t.price;
      hist_head = (hist_head + 1) % WINDOW_MAX;
      sum_acc += 64'(t.price);
      sq_acc  += 64'(t.price) * 64'(t.price);
      if (hist_count >= n) begin
         mid = sum_acc / n;
         a = 128'(sq_acc) * n;
         b = 128'(sum_acc) * 128'(sum_acc);
         spread = (a <= b) ? '0 : a - b;
         off = (64'(bw_reg) * root_floor(spread)) / (64'(n) * 256);
         res.middle_band = mid[PRICE_W-1:0];
         res.upper_band  = BAND_W'(mid + off);
         res.lower_band  = BAND_W'(mid - off);
         res.window_full = 1'b1;
      end else begin
         res.middle_band = t.price;
         res.upper_band  = BAND_W'(t.price);
         res.lower_band  = BAND_W'(t.price);
         res.window_full = 1'b0;
      end
      return res;
   endfunction

   // --- driver: bursts of items with random gaps ---------------------------
   int gap_left   = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req.valid   <= 1'b0;
         req.price   <= '0;
         req.restart <= 1'b0;
      end else begin
         // retire the accepted item and predict its result
         if (req.valid && req.ready) begin
            band_mem[band_wr] = predict_bands(tick_mem[tick_rd]);
            band_wr++;
            tick_rd++;
         end
         if ((!req.valid || req.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (tick_rd != tick_wr) begin
               req.valid   <= 1'b1;
               req.price   <= tick_mem[tick_rd].price;
               req.restart <= tick_mem[tick_rd].restart;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // --- monitor: stalling receiver and field-by-field check ---------------
   int stall_phase = 0;

   always @(posedge clock) begin
      band_result_type exp_res;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (band_rd == band_wr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: middle %0d", rsp.middle_band);
            end else begin
               exp_res = band_mem[band_rd];
               band_rd++;
               if (rsp.middle_band !== exp_res.middle_band
                   || rsp.upper_band !== exp_res.upper_band
                   || rsp.lower_band !== exp_res.lower_band
                   || rsp.window_full !== exp_res.window_full) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"band mismatch: exp mid %0d up %0d lo %0d full %0b,",
                               " got mid %0d up %0d lo %0d full %0b"},
                              exp_res.middle_band, exp_res.upper_band,
                              exp_res.lower_band, exp_res.window_full,
                              rsp.middle_band, rsp.upper_band,
                              rsp.lower_band, rsp.window_full);
               end
            end
         end
         // stall pattern: long open stretches, then bursts of back-pressure
         stall_phase = (stall_phase + 1) % 400;
         rsp.ready <= (stall_phase < 150) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   // --- timeout ------------------------------------------------------------
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // --- register writes, only while idle -----------------------------------
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      // model the write at the accepting edge
      if (idx == REG_WINDOW_LENGTH) begin
         len_reg = value[LEN_W-1:0];
         clear_window();
      end else if (idx == REG_BAND_WIDTH) begin
         bw_reg = value[BW_W-1:0];
      end
      csr.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (tick_rd != tick_wr || req.valid || band_rd != band_wr)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic tick_type rand_tick(int restart_odds);
      tick_type t;
      case ($urandom_range(0, 5))
         0:       t.price = PRICE_W'($urandom_range(0, 255));
         1:       t.price = {PRICE_W{1'b1}} - PRICE_W'($urandom_range(0, 255));
         default: t.price = PRICE_W'($urandom);
      endcase
      t.restart = ($urandom_range(1, restart_odds) == 1);
      return t;
   endfunction

   function automatic void add_tick(tick_type t);
      tick_mem[tick_wr] = t;
      tick_wr++;
   endfunction

   task automatic push_tick(logic [PRICE_W-1:0] p, logic r);
      tick_type t;
      t.price   = p;
      t.restart = r;
      add_tick(t);
   endtask

   // --- stimulus -----------------------------------------------------------
   initial begin
      int lens [6] = '{20, 1, 64, 2, 7, 0};
      int bws  [6] = '{512, 4095, 0, 1, 777, 2048};
      csr.valid = 1'b0;
      csr.index = REG_WINDOW_LENGTH;
      csr.data  = '0;
      len_reg = LEN_RESET;
      bw_reg  = BW_RESET;
      clear_window();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, extremes, restart mid-window
      push_tick('0, 1'b0);
      push_tick({PRICE_W{1'b1}}, 1'b0);
      push_tick(24'h555555, 1'b0);
      push_tick(24'hAAAAAA, 1'b1);
      for (int i = 0; i < 20; i++) push_tick((i % 2) ? {PRICE_W{1'b1}} : '0, 1'b0);
      wait_idle();

      // length 1 and oversize length (saturates), maximum band width
      write_reg(REG_WINDOW_LENGTH, 12'd1);
      write_reg(REG_BAND_WIDTH, 12'd4095);
      push_tick(24'h123456, 1'b0);
      push_tick(24'hFFFFFF, 1'b0);
      wait_idle();
      write_reg(REG_WINDOW_LENGTH, 12'd127);
      for (int i = 0; i < 70; i++) push_tick((i % 3) ? {PRICE_W{1'b1}} : '0, 1'b0);
      wait_idle();
      write_reg(csr_index_type'(2'd3), 12'hFFF);  // unknown index, ignored
      wait_idle();

      // random phases over several register settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_WINDOW_LENGTH, 12'(lens[ph]));
         write_reg(REG_BAND_WIDTH, 12'(bws[ph]));
         for (int i = 0; i < 330; i++) add_tick(rand_tick(60));
         wait_idle();
      end

      if (mismatches == 0 && band_rd == band_wr) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/rwbb_pkg.sv
src/rwbb_req_if.sv
src/rwbb_rsp_if.sv
src/rwbb_csr_if.sv
src/rwbb_ring_ram.sv
src/rwbb_isqrt.sv
src/rwbb_div.sv
src/rolling_window_bollinger_bands_top.sv
dv/tb_rwbb_if.sv
dv/tb_rolling_window_bollinger_bands_top.sv
